[rtl/cc20_pkg.sv]
`default_nettype none
package cc20_pkg;

    localparam int ROUND_COUNT = 20;
    localparam int STEP_COUNT  = 2 * ROUND_COUNT;
    localparam int STEP_W      = $clog2(STEP_COUNT);
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam int CFG_IDX_W   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY0,
        CFG_KEY1,
        CFG_KEY2,
        CFG_KEY3,
        CFG_NONCE,
        CFG_START
    } cfg_idx_t;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_ROUND,
        BK_FINAL
    } bk_state_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        new_block;
        logic [5:0]  pos;
        logic [31:0] ctr;
    } item_t;

    typedef struct packed {
        logic [63:0] k0;
        logic [63:0] k1;
        logic [63:0] k2;
        logic [63:0] k3;
        logic [63:0] nonce;
    } key_t;

    typedef logic [15:0][31:0] blk_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [127:0] qr_half(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d,
                                             input logic second);
        logic [31:0] a2;
        logic [31:0] b2;
        logic [31:0] c2;
        logic [31:0] d2;
        a2 = a + b;
        d2 = second ? rotl(d ^ a2, 8) : rotl(d ^ a2, 16);
        c2 = c + d2;
        b2 = second ? rotl(b ^ c2, 7) : rotl(b ^ c2, 12);
        return {a2, b2, c2, d2};
    endfunction

    function automatic blk_t make_init(input key_t k, input logic [31:0] ctr);
        blk_t s;
        s      = '0;
        s[0]   = k.k0[31:0];
        s[1]   = k.k0[63:32];
        s[2]   = k.k1[31:0];
        s[3]   = k.k1[63:32];
        s[4]   = k.k2[31:0];
        s[5]   = k.k2[63:32];
        s[6]   = k.k3[31:0];
        s[7]   = k.k3[63:32];
        s[8]   = k.nonce[31:0];
        s[9]   = k.nonce[63:32];
        s[12]  = ctr;
        return s;
    endfunction

endpackage
`default_nettype wire

[rtl/chacha20_stream_cipher_core.sv]
`default_nettype none
// Channel   Ports                               Direction
// input     s_valid s_ready s_data_byte s_last_byte   in
// result    m_valid m_ready m_result_byte m_result_last out
// config    cfg_valid cfg_ready cfg_index cfg_data    in
//
// Bytes inside a block pass at one byte per cycle while m_ready does not stall;
// the first byte of each 64-byte block waits for the iterative round core,
// two half quarter-round steps per round on all four columns or diagonals.
// A four-entry queue lets the front keep taking bytes while the core runs.
// aresetn is synchronous, active low; the result register stalls on m_ready.
module chacha20_stream_cipher_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [7:0]                      s_data_byte,
    input  wire logic                            s_last_byte,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [7:0]                           m_result_byte,
    output logic                                 m_result_last,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [63:0]                     cfg_data
);
    import cc20_pkg::*;

    key_t  key;
    logic  q_push;
    item_t q_item;
    logic  q_ready;
    logic  q_pop;
    logic  head_valid;
    item_t head;

    cc20_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .key         (key),
        .q_push      (q_push),
        .q_item      (q_item),
        .q_ready     (q_ready)
    );

    cc20_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (q_item),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head       (head)
    );

    cc20_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .key           (key),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_byte (m_result_byte),
        .m_result_last (m_result_last)
    );

endmodule
`default_nettype wire

[rtl/cc20_front.sv]
`default_nettype none
module cc20_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [7:0]                      s_data_byte,
    input  wire logic                            s_last_byte,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [63:0]                     cfg_data,
    output cc20_pkg::key_t                       key,
    output logic                                 q_push,
    output cc20_pkg::item_t                      q_item,
    input  wire logic                            q_ready
);
    import cc20_pkg::*;

    key_t        key_reg;
    logic [31:0] start_reg;
    logic        in_msg_reg;
    logic [5:0]  pos_reg;
    logic [31:0] ctr_reg;
    logic [31:0] ctr_use;
    logic [5:0]  pos_use;

    assign cfg_ready = 1'b1;
    assign s_ready   = q_ready;
    assign q_push    = s_valid && q_ready;
    assign key       = key_reg;
    assign ctr_use   = in_msg_reg ? ctr_reg : start_reg;
    assign pos_use   = in_msg_reg ? pos_reg : 6'd0;

    always_comb begin
        q_item           = '0;
        q_item.data      = s_data_byte;
        q_item.last      = s_last_byte;
        q_item.new_block = (pos_use == 6'd0);
        q_item.pos       = pos_use;
        q_item.ctr       = ctr_use;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg   <= '0;
            start_reg <= 32'd1;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_KEY0:  key_reg.k0    <= cfg_data;
                CFG_KEY1:  key_reg.k1    <= cfg_data;
                CFG_KEY2:  key_reg.k2    <= cfg_data;
                CFG_KEY3:  key_reg.k3    <= cfg_data;
                CFG_NONCE: key_reg.nonce <= cfg_data;
                CFG_START: start_reg     <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_msg_reg <= 1'b0;
            pos_reg    <= '0;
            ctr_reg    <= 32'd1;
        end else if (q_push) begin
            if (pos_use == 6'd0) begin
                ctr_reg <= ctr_use + 32'd1;
            end else begin
                ctr_reg <= ctr_use;
            end
            if (s_last_byte) begin
                in_msg_reg <= 1'b0;
                pos_reg    <= '0;
            end else begin
                in_msg_reg <= 1'b1;
                pos_reg    <= pos_use + 6'd1;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/cc20_queue.sv]
`default_nettype none
module cc20_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire cc20_pkg::item_t  push_item,
    output logic                  push_ready,
    input  wire logic             pop,
    output logic                  head_valid,
    output cc20_pkg::item_t       head
);
    import cc20_pkg::*;

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign push_ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> push_ready) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid) else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCNT_W'(QDEPTH)) else $error("queue count out of range");

endmodule
`default_nettype wire

[rtl/cc20_back.sv]
`default_nettype none
module cc20_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cc20_pkg::key_t   key,
    input  wire logic             head_valid,
    input  wire cc20_pkg::item_t  head,
    output logic                  pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [7:0]            m_result_byte,
    output logic                  m_result_last
);
    import cc20_pkg::*;

    bk_state_t         state_reg;
    bk_state_t         state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    blk_t              w_reg;
    blk_t              w_next;
    blk_t              ks_reg;
    blk_t              init;
    blk_t              half;
    logic              done_reg;
    logic              done_next;
    logic              m_valid_reg;
    logic [7:0]        byte_reg;
    logic              last_reg;
    logic [31:0]       ks_word;
    logic [7:0]        ks_byte;
    logic [127:0]      qr;

    assign init    = make_init(key, head.ctr);
    assign ks_word = ks_reg[head.pos[5:2]];
    assign ks_byte = 8'(ks_word >> {head.pos[1:0], 3'b000});
    assign pop     = head_valid && (state_reg == BK_RUN) && (!head.new_block || done_reg)
                     && (!m_valid_reg || m_ready);

    assign m_valid       = m_valid_reg;
    assign m_result_byte = byte_reg;
    assign m_result_last = last_reg;

    always_comb begin
        half = w_reg;
        qr   = '0;
        for (int i = 0; i < 4; i++) begin
            if (!step_reg[1]) begin
                qr = qr_half(w_reg[i], w_reg[4 + i], w_reg[8 + i], w_reg[12 + i],
                             step_reg[0]);
                half[i]      = qr[127:96];
                half[4 + i]  = qr[95:64];
                half[8 + i]  = qr[63:32];
                half[12 + i] = qr[31:0];
            end else begin
                qr = qr_half(w_reg[i], w_reg[4 + ((i + 1) % 4)],
                             w_reg[8 + ((i + 2) % 4)], w_reg[12 + ((i + 3) % 4)],
                             step_reg[0]);
                half[i]                  = qr[127:96];
                half[4 + ((i + 1) % 4)]  = qr[95:64];
                half[8 + ((i + 2) % 4)]  = qr[63:32];
                half[12 + ((i + 3) % 4)] = qr[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_RUN;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        w_next     = w_reg;
        done_next  = done_reg;
        case (state_reg)
            BK_RUN: begin
                if (pop) begin
                    done_next = 1'b0;
                end else if (head_valid && head.new_block && !done_reg) begin
                    w_next     = init;
                    step_next  = '0;
                    state_next = BK_ROUND;
                end
            end
            BK_ROUND: begin
                w_next    = half;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(STEP_COUNT - 1)) begin
                    state_next = BK_FINAL;
                end
            end
            BK_FINAL: begin
                done_next  = 1'b1;
                state_next = BK_RUN;
            end
            default: begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        w_reg <= w_next;
        if (state_reg == BK_FINAL) begin
            for (int i = 0; i < 16; i++) begin
                ks_reg[i] <= w_reg[i] + init[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            byte_reg <= head.data ^ ks_byte;
            last_reg <= head.last;
        end
    end

    a_pop_has_block: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && head.new_block |-> done_reg) else $error("byte sent before block ready");
    a_final_after_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_FINAL |-> $past(state_reg) == BK_ROUND)
        else $error("feed-forward without rounds");
    a_done_after_final: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_FINAL |=> done_reg) else $error("block not marked ready");

endmodule
`default_nettype wire
